/* design/sdeq_pkg.sv */
// ----------------------------------------------------------------------------
// sdeq_pkg
// Shared constants and types of the sorted delay event queue.
// ----------------------------------------------------------------------------
package sdeq_pkg;
  localparam int unsigned DefDepth    = 32;
  localparam int unsigned DefKeyWidth = 32;
  localparam int unsigned TolWidth    = 32;
  localparam int unsigned IdxWidth    = 16;
  localparam int unsigned OutKeyWidth = 32;
  localparam int unsigned OccWidth    = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP     = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [IdxWidth-1:0] species_index;
    logic [IdxWidth-1:0] reaction_index;
    logic [31:0]         delay_time;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [IdxWidth-1:0]    out_species;
    logic [IdxWidth-1:0]    out_reaction;
    logic [OutKeyWidth-1:0] out_delay;
    logic                   last;
    logic [OccWidth-1:0]    occupancy;
  } rsp_t;
endpackage

/* design/sdeq_if.sv */
// ----------------------------------------------------------------------------
// sdeq_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sdeq_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/sdeq_ram.sv */
// ----------------------------------------------------------------------------
// sdeq_ram
// One-port-write, one-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sdeq_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/sorted_delay_event_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_delay_event_queue_core
// Sorted event queue held in one RAM ring, with a sequencer.
// ----------------------------------------------------------------------------
// One request at a time. Insert scans from the tail toward the head, moving
// each entry with a greater key up one slot: each moved entry takes a RAM
// read, then a compare and write. Pop reads the head entry, then takes it;
// extract takes the head alike, then reads and checks each further event in
// turn, and stalls while a result waits. The single RAM read port sets the
// rate. Results sit in an output register, so the next request may arrive
// while one waits.
module sorted_delay_event_queue_core #(
  parameter int unsigned DEPTH     = sdeq_pkg::DefDepth,
  parameter int unsigned KEY_WIDTH = sdeq_pkg::DefKeyWidth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sdeq_if.sink   req_i,
  sdeq_if.sink   cfg_i,
  sdeq_if.source rsp_o
);
  import sdeq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_WIDTH + 2 * IdxWidth;
  localparam int unsigned DW = (KEY_WIDTH + 1 > TolWidth) ? KEY_WIDTH + 1 : TolWidth;

  typedef enum logic [2:0] {
    S_IDLE, S_IRD, S_ICMP, S_HRD, S_HOUT, S_XRD, S_XCHK, S_WAIT
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       head_q;
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       pos_q;
  logic [TolWidth-1:0] tol_q;
  logic [KEY_WIDTH-1:0] least_q;
  req_t                req_q;
  rsp_t                rsp_q;
  logic                rsp_v_q;
  rsp_t                pend_q;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rdata;
  logic [KEY_WIDTH-1:0] nkey, rkey;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(p);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign nkey  = KEY_WIDTH'(req_q.delay_time);
  assign rkey  = rdata[EW-1 -: KEY_WIDTH];
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.data  = rsp_q;

  sdeq_ram #(.Depth(DEPTH), .Width(EW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic ins_stop;
  logic [KEY_WIDTH:0] diff;
  logic in_win;
  assign ins_stop = (pos_q == '0) || (rkey <= nkey);
  assign diff     = {1'b0, rkey} - {1'b0, least_q};
  assign in_win   = (DW'(diff) <= DW'(tol_q));

  always_comb begin
    we    = 1'b0;
    waddr = slot(head_q, pos_q);
    wdata = rdata;
    raddr = slot(head_q, pos_q - CW'(1));
    unique case (state_q)
      S_ICMP: begin
        we = 1'b1;
        if (ins_stop) begin
          wdata = {nkey, req_q.species_index, req_q.reaction_index};
        end
      end
      S_IDLE, S_HRD, S_HOUT, S_XRD, S_XCHK: raddr = head_q;
      default: ;
    endcase
  end

  // Form the result from RAM read data; pend_q keeps it until the output register frees.
  rsp_t emit;
  always_comb begin
    emit.status       = ST_OK;
    emit.out_species  = rdata[2*IdxWidth-1:IdxWidth];
    emit.out_reaction = rdata[IdxWidth-1:0];
    emit.out_delay    = OutKeyWidth'(rkey);
    emit.last         = 1'b1;
    emit.occupancy    = OccWidth'(cnt_q - CW'(1));
  end

  // Hand the pending result to the output register once it is free.
  logic rsp_load;
  rsp_t rsp_d;
  always_comb begin
    rsp_load = ((state_q == S_WAIT) || (state_q == S_XCHK)) && (!rsp_v_q || rsp_o.ready);
    rsp_d    = pend_q;
    if (state_q == S_XCHK) begin
      rsp_d.last = !in_win;
    end
  end

  function automatic rsp_t simple(input status_e st, input logic [CW-1:0] occ);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    r.occupancy = OccWidth'(occ);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
      tol_q <= TolWidth'(1);
      least_q <= '0;
      req_q <= '0;
      rsp_q <= '0;
      pend_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) tol_q <= cfg_i.data;
      if (rsp_load) begin
        rsp_q <= rsp_d;
        rsp_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (req_i.valid) begin
          req_q <= req_i.data;
          unique case (op_e'(req_i.data.op))
            OP_INSERT: begin
              if (cnt_q >= CW'(DEPTH)) begin
                pend_q <= simple(ST_FULL, cnt_q);
                state_q <= S_WAIT;
              end else begin
                pos_q <= cnt_q;
                state_q <= S_IRD;
              end
            end
            OP_NONE: begin
              pend_q <= simple(ST_OK, cnt_q);
              state_q <= S_WAIT;
            end
            default: begin
              if (cnt_q == '0) begin
                pend_q <= simple(ST_EMPTY, cnt_q);
                state_q <= S_WAIT;
              end else begin
                state_q <= S_HRD;
              end
            end
          endcase
        end
        S_IRD: state_q <= S_ICMP;
        S_ICMP: begin
          if (ins_stop) begin
            cnt_q <= cnt_q + CW'(1);
            pend_q <= simple(ST_OK, cnt_q + CW'(1));
            state_q <= S_WAIT;
          end else begin
            pos_q <= pos_q - CW'(1);
            state_q <= S_IRD;
          end
        end
        S_HRD: state_q <= S_HOUT;
        S_HOUT: begin
          // first head entry read: take it, remember least key
          least_q <= rkey;
          pend_q <= emit;
          head_q <= slot(head_q, CW'(1));
          cnt_q <= cnt_q - CW'(1);
          if (op_e'(req_q.op) == OP_POP || cnt_q == CW'(1)) begin
            state_q <= S_WAIT;
          end else begin
            state_q <= S_XRD;
          end
        end
        S_XRD: state_q <= S_XCHK;
        S_XCHK: begin
          // decide last flag of the pending one, then hand it off
          if (rsp_load) begin
            if (in_win) begin
              pend_q <= emit;
              head_q <= slot(head_q, CW'(1));
              cnt_q <= cnt_q - CW'(1);
              state_q <= (cnt_q == CW'(1)) ? S_WAIT : S_XRD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_WAIT: begin
          if (rsp_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/sdeq_checker.sv */
// ----------------------------------------------------------------------------
// sdeq_checker
// Port-level checks of the event queue, bound to the queue core.
// ----------------------------------------------------------------------------
module sdeq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input sdeq_pkg::rsp_t   rsp_data
);
  import sdeq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.status != ST_RSVD)
    else $error("reserved status");

  a_nonok_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last)
    else $error("error result not last");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.occupancy == '0)
    else $error("empty with entries");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");
endmodule

bind sorted_delay_event_queue_core sdeq_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid(req_i.valid), .req_ready(req_i.ready),
  .rsp_valid(rsp_o.valid), .rsp_ready(rsp_o.ready), .rsp_data(rsp_o.data)
);
